@@ hw/rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the serial frame deframer
// Frame marker bytes, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame marker bytes
  localparam logic [7:0] HEAD0_BYTE = 8'h55;
  localparam logic [7:0] HEAD1_BYTE = 8'hAA;
  localparam logic [7:0] TYPE_BYTE  = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h5A;

  // length byte is a bit count, rounded up to whole bytes
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam logic [8:0]  ROUND_UP      = 9'(BITS_PER_BYTE - 1);

  // result field widths
  localparam int unsigned IDX_W = 5;
  localparam int unsigned CNT_W = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_len;   // length byte: clear counters, latch byte count
    logic store_data; // payload byte: write store, add to sum
    logic emit_run;   // drain the store to the output
  } ctl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_head0;
    logic is_head1;
    logic is_type;
    logic is_end;
    logic len_zero;
    logic len_too_long;
    logic data_full;
    logic sum_match;
    logic exp_zero;
    logic emit_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/sfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfd_ctrl: frame parser state machine
// Walks the header, type, length, payload, sum and end bytes and runs the
// payload drain. Holds the rx_enable register.
// ----------------------------------------------------------------------------
module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_valid,
  input  logic     cfg_rx_enable,
  input  logic     in_fire,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  localparam logic [2:0] PH_HEAD0 = 3'd0;
  localparam logic [2:0] PH_HEAD1 = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;
  localparam logic [2:0] PH_EMIT  = 3'd7;

  logic [2:0] phase_r, phase_nxt;
  logic       rx_enable_r;
  logic       step;

  // enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      rx_enable_r <= cfg_rx_enable;
    end
  end

  // a word only advances the parser while enabled
  assign step = in_fire && rx_enable_r;

  // next phase and datapath commands
  always_comb begin
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (phase_r)
      PH_HEAD0: if (step && stat.is_head0) phase_nxt = PH_HEAD1;
      PH_HEAD1: if (step) phase_nxt = stat.is_head1 ? PH_TYPE : PH_HEAD0;
      PH_TYPE:  if (step) phase_nxt = stat.is_type ? PH_LEN : PH_HEAD0;
      PH_LEN: begin
        if (step) begin
          cmd.load_len = 1'b1;
          priority if (stat.len_too_long) phase_nxt = PH_HEAD0;
          else if (stat.len_zero)         phase_nxt = PH_SUM;
          else                            phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (step) begin
          cmd.store_data = 1'b1;
          if (stat.data_full) phase_nxt = PH_SUM;
        end
      end
      PH_SUM: if (step) phase_nxt = stat.sum_match ? PH_END : PH_HEAD0;
      PH_END: begin
        if (step) begin
          phase_nxt = (stat.is_end && !stat.exp_zero) ? PH_EMIT : PH_HEAD0;
        end
      end
      PH_EMIT: begin
        cmd.emit_run = 1'b1;
        if (stat.emit_done) phase_nxt = PH_HEAD0;
      end
      default: phase_nxt = PH_HEAD0;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign busy = (phase_r == PH_EMIT);

endmodule

@@ hw/rtl/sfd_datapath.sv @@
// ----------------------------------------------------------------------------
// sfd_datapath: byte compares, counters, checksum, payload store and output
// The store is written one word per payload byte and drained through a
// registered read stage and an output register.
// ----------------------------------------------------------------------------
module sfd_datapath
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       rx_byte,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_payload_byte,
  output logic [IDX_W-1:0] out_byte_index,
  output logic [CNT_W-1:0] out_byte_count,
  output logic             out_last
);

  localparam int unsigned AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(MAX_PAYLOAD_BYTES);

  logic [7:0]       mem [MAX_PAYLOAD_BYTES];
  logic [CNT_W-1:0] expected_r, received_r, emit_idx_r;
  logic [7:0]       sum_r;
  logic [8:0]       len_sum;
  logic [CNT_W-1:0] len_bytes;
  logic [CNT_W-1:0] emit_idx_inc;
  logic             issue, emit_last, move;

  // read stage and output slot
  logic             rd_vld_r;
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rd_last_r;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_last_r;

  // length in whole bytes, 0..32
  assign len_sum   = {1'b0, rx_byte} + ROUND_UP;
  assign len_bytes = CNT_W'(len_sum >> 3);

  // status to the controller
  assign stat.is_head0     = (rx_byte == HEAD0_BYTE);
  assign stat.is_head1     = (rx_byte == HEAD1_BYTE);
  assign stat.is_type      = (rx_byte == TYPE_BYTE);
  assign stat.is_end       = (rx_byte == END_BYTE);
  assign stat.len_zero     = (len_bytes == '0);
  assign stat.len_too_long = (len_bytes > MAX_BYTES);
  assign stat.data_full    = ((received_r + 1'b1) >= expected_r);
  assign stat.sum_match    = (rx_byte == sum_r);
  assign stat.exp_zero     = (expected_r == '0);
  assign stat.emit_done    = issue && emit_last;

  // frame counters and checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
      received_r <= '0;
      sum_r      <= '0;
    end else if (cmd.load_len) begin
      expected_r <= stat.len_too_long ? '0 : len_bytes;
      received_r <= '0;
      sum_r      <= '0;
    end else if (cmd.store_data) begin
      received_r <= received_r + 1'b1;
      sum_r      <= sum_r + rx_byte;
    end
  end

  // payload store write
  always_ff @(posedge clk) begin
    if (cmd.store_data) begin
      mem[received_r[AW-1:0]] <= rx_byte;
    end
  end

  // drain: one read per cycle while the read stage is free or moving
  assign move         = rd_vld_r && (!out_valid_r || !out_stall);
  assign issue        = cmd.emit_run && (!rd_vld_r || move);
  assign emit_idx_inc = emit_idx_r + 1'b1;
  assign emit_last    = (emit_idx_inc == expected_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r <= '0;
    end else if (issue) begin
      emit_idx_r <= emit_last ? '0 : emit_idx_inc;
    end
  end

  // registered store read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[emit_idx_r[AW-1:0]];
      rd_idx_r  <= emit_idx_r[IDX_W-1:0];
      rd_cnt_r  <= expected_r;
      rd_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (issue) begin
      rd_vld_r <= 1'b1;
    end else if (move) begin
      rd_vld_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= rd_data_r;
      out_idx_r  <= rd_idx_r;
      out_cnt_r  <= rd_cnt_r;
      out_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_data_r;
  assign out_byte_index   = out_idx_r;
  assign out_byte_count   = out_cnt_r;
  assign out_last         = out_last_r;

endmodule

@@ hw/rtl/serial_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// serial_frame_deframer: byte frame parser with additive checksum
// Parses 0x55 0xAA, type 1, bit length, payload, sum and 0x5A end byte, and
// emits the payload of each verified frame one byte per word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | in        | in_valid/in_stall  | in_rx_byte
//  out     | out       | out_valid/out_stall| payload_byte, byte_index, count, last
//  cfg     | in        | cfg_valid/cfg_ready| cfg_rx_enable
//
//  The parser takes one input word per cycle while in_stall is low. A good end
//  byte starts a drain of N payload bytes from the store, one read per cycle
//  unless out_stall holds the output, through a registered read stage and the
//  output register. in_stall is high from the good end byte until the last
//  store read issues, which out_stall can delay by holding the output.
//  Synchronous active-low reset; the store needs no clearing pass.
//
module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_rx_enable,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_payload_byte,
  output logic [IDX_W-1:0] out_byte_index,
  output logic [CNT_W-1:0] out_byte_count,
  output logic             out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     busy;
  logic     in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;

  // parser controller
  sfd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_rx_enable (cfg_rx_enable),
    .in_fire       (in_fire),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy)
  );

  // counters, store and output
  sfd_datapath #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_byte          (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_byte_count   (out_byte_count),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // last word sits at the final index of its frame
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (CNT_W'(out_byte_index) + 1'b1) == out_byte_count)
    else $error("last flag not on final payload index");

  // every index lies within the frame's byte count
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CNT_W'(out_byte_index) < out_byte_count)
    else $error("payload index beyond byte count");

  // drain completion is flagged only in the drain phase
  a_drain_only: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit_done |-> busy && cmd.emit_run)
    else $error("drain completion outside drain phase");
`endif

endmodule
